[hw/rtl/assert_macros.svh]
// Assertion macros shared by the edge detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define LE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LE_ASSERT(lbl, clk, rst, prop)
`define LE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hw/rtl/lap_edge_pkg.sv]
// Types and constants of the 5x5 Laplacian edge detector.
package lap_edge_pkg;

  localparam int PIX_W          = 8;
  localparam int LINE_WIDTH_W   = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int THRESH_W       = 14;
  localparam int CFG_DATA_W     = 14;
  localparam int CFG_INDEX_W    = 2;
  localparam int OUT_ROW_W      = 12;
  localparam int OUT_COL_W      = 11;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int LINE_WIDTH_RST   = 1280;
  localparam int FRAME_HEIGHT_RST = 720;

  localparam int KSIZE       = 5;
  localparam int LINES       = KSIZE - 1;
  localparam int SLOT_W      = 2;
  localparam int BORDER      = 2;
  localparam int CENTRE_GAIN = 24;
  localparam int COLSUM_W    = 11;
  localparam int SUM_W       = 13;
  localparam int RESP_W      = SUM_W + 2;
  localparam int SAT_MAX     = 255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LINE_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] grey_pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0]     edge_value;
    logic                 out_valid;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
  } res_t;

  typedef struct packed {
    logic                 ov;
    logic                 inner;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } pos_t;

  typedef logic [LINES-1:0][PIX_W-1:0] col_t;

endpackage

[hw/rtl/lap_edge_linebuf.sv]
// Line store memory with read-modify-write of one column word and write forwarding.
`include "assert_macros.svh"

module lap_edge_linebuf #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                    rd_addr,
  input  logic                                            wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                    wr_addr,
  input  logic [lap_edge_pkg::SLOT_W-1:0]                 wr_slot,
  input  logic [lap_edge_pkg::PIX_W-1:0]                  wr_pixel,
  output lap_edge_pkg::col_t                              column
);
  import lap_edge_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  col_t mem [MAX_WIDTH];
  col_t rd_data;
  col_t fwd_word;
  logic fwd;
  col_t base;
  col_t word_wr;

  always_comb begin
    base = fwd ? fwd_word : rd_data;
    word_wr = base;
    word_wr[wr_slot] = wr_pixel;
    for (int k = 0; k < LINES; k++) begin
      column[k] = base[SLOT_W'(wr_slot + SLOT_W'(k))];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= word_wr;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      fwd_word <= word_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  logic [AW-1:0] last_wr_addr;
  logic          last_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr <= 1'b0;
    end else begin
      last_wr <= wr_en && rd_en;
    end
    last_wr_addr <= rd_addr;
  end

  `LE_ASSERT(a_fwd_on_collision, clk, rst, rd_en && wr_en && (rd_addr == wr_addr) |=> fwd)
  `LE_ASSERT(a_fwd_needs_write, clk, rst, rd_en && !wr_en |=> !fwd)
  `LE_ASSERT(a_fwd_same_entry, clk, rst, fwd && last_wr |-> $past(wr_addr) == last_wr_addr)

endmodule

[hw/rtl/lap_edge_window.sv]
// Window column sums, centre pixel line and the Laplacian response register.
module lap_edge_window (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      shift_en,
  input  lap_edge_pkg::col_t                        up,
  input  logic [lap_edge_pkg::PIX_W-1:0]            pixel,
  input  logic                                      load_en,
  output logic signed [lap_edge_pkg::RESP_W-1:0]    resp
);
  import lap_edge_pkg::*;

  logic [KSIZE-1:0][COLSUM_W-1:0] colsum;
  logic [BORDER:0][PIX_W-1:0]     ctr;
  logic [COLSUM_W-1:0]            new_sum;
  logic [SUM_W-1:0]               total;
  logic [SUM_W-1:0]               scaled;

  always_comb begin
    new_sum = COLSUM_W'(pixel);
    for (int k = 0; k < LINES; k++) begin
      new_sum = new_sum + COLSUM_W'(up[k]);
    end
    total = '0;
    for (int j = 0; j < KSIZE; j++) begin
      total = total + SUM_W'(colsum[j]);
    end
    scaled = SUM_W'(CENTRE_GAIN + 1) * SUM_W'(ctr[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colsum <= '0;
      ctr    <= '0;
    end else if (shift_en) begin
      for (int j = 0; j < KSIZE - 1; j++) begin
        colsum[j] <= colsum[j+1];
      end
      colsum[KSIZE-1] <= new_sum;
      for (int j = 0; j < BORDER; j++) begin
        ctr[j] <= ctr[j+1];
      end
      ctr[BORDER] <= up[BORDER];
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      resp <= $signed({2'b00, scaled}) - $signed({2'b00, total});
    end
  end

endmodule

[hw/rtl/laplacian_edge_threshold_5x5_unit.sv]
// Top level of the streaming 5x5 Laplacian edge detector with threshold.
//
// Grey pixels enter in raster order on the pix channel (valid/stall); one
// transaction is taken when pix_valid is high and pix_stall is low. Each
// input transaction produces exactly one result transaction on the res
// channel, reporting the window centre two rows and two columns behind it.
// The four line stores live in one memory of MAX_WIDTH words, one byte per
// stored row, read at acceptance and written back as the pixel leaves stage a.
// Each pixel passes the a, b and c stage registers and then the res register;
// one pixel is taken every cycle when the output is not stalled, kept up by
// the read-modify-write of the line store word with write forwarding.
// Registers are written on the cfg channel (valid/ready, always ready):
// index 0 sets the line width, 1 the frame height, 2 the threshold on edge values.
// Synchronous reset empties the pipeline, zeroes the counters and window,
// and loads the register defaults; line store contents stay undefined.
// When res_stall is held, the result holds and upstream stages fill their
// bubbles before pix_stall rises.
`include "assert_macros.svh"

module laplacian_edge_threshold_5x5_unit #(
  parameter int MAX_WIDTH  = lap_edge_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lap_edge_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     pix_valid,
  output logic                                     pix_stall,
  input  lap_edge_pkg::pix_t                       pix,
  output logic                                     res_valid,
  input  logic                                     res_stall,
  output lap_edge_pkg::res_t                       res,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [lap_edge_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lap_edge_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lap_edge_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = CW + 1;
  localparam int EH = RW + 1;

  logic [LINE_WIDTH_W-1:0]    line_width;
  logic [FRAME_HEIGHT_W-1:0]  frame_height;
  logic signed [THRESH_W-1:0] edge_threshold;

  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;

  logic [RW-1:0] row_cnt;
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] r_cur;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] row_cnt_next;
  logic [CW-1:0] col_cnt_next;
  pos_t          pos_cur;

  logic                a_valid, b_valid, c_valid;
  pos_t                a_pos, b_pos, c_pos;
  logic [PIX_W-1:0]    a_pixel;
  logic [SLOT_W-1:0]   a_slot;
  logic [CW-1:0]       a_col;

  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic acc, mv_ab, mv_bc, mv_cd;

  col_t                       column;
  logic signed [RESP_W-1:0]   resp;
  logic [PIX_W-1:0]           value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= LINE_WIDTH_W'(LINE_WIDTH_RST);
      frame_height   <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
      edge_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_WIDTH:     line_width     <= cfg_data[LINE_WIDTH_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[FRAME_HEIGHT_W-1:0];
        CFG_EDGE_THRESHOLD: edge_threshold <= $signed(cfg_data[THRESH_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width < LINE_WIDTH_W'(KSIZE)) begin
      eff_w = EW'(KSIZE);
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(line_width);
    end
    if (frame_height < FRAME_HEIGHT_W'(KSIZE)) begin
      eff_h = EH'(KSIZE);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(frame_height);
    end
  end

  assign rdy_d     = !res_valid || !res_stall;
  assign mv_cd     = c_valid && rdy_d;
  assign rdy_c     = !c_valid || rdy_d;
  assign mv_bc     = b_valid && rdy_c;
  assign rdy_b     = !b_valid || rdy_c;
  assign mv_ab     = a_valid && rdy_b;
  assign rdy_a     = !a_valid || rdy_b;
  assign pix_stall = !rdy_a;
  assign acc       = pix_valid && rdy_a;

  always_comb begin
    r_cur = pix.frame_start ? '0 : row_cnt;
    c_cur = pix.frame_start ? '0 : col_cnt;
    if (EW'(c_cur) + EW'(1) >= eff_w) begin
      col_cnt_next = '0;
      row_cnt_next = (EH'(r_cur) + EH'(1) >= eff_h) ? '0 : r_cur + RW'(1);
    end else begin
      col_cnt_next = c_cur + CW'(1);
      row_cnt_next = r_cur;
    end
    pos_cur.ov    = (32'(r_cur) >= 32'(BORDER)) && (32'(c_cur) >= 32'(BORDER));
    pos_cur.inner = (32'(r_cur) >= 32'(2 * BORDER)) && (32'(c_cur) >= 32'(2 * BORDER))
                    && (EW'(c_cur) < eff_w) && (EH'(r_cur) < eff_h);
    if (pos_cur.ov) begin
      pos_cur.row = OUT_ROW_W'(32'(r_cur) - 32'(BORDER));
      pos_cur.col = OUT_COL_W'(32'(c_cur) - 32'(BORDER));
    end else begin
      pos_cur.row = '0;
      pos_cur.col = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (acc) begin
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (acc) begin
        a_valid <= 1'b1;
      end else if (mv_ab) begin
        a_valid <= 1'b0;
      end
      if (mv_ab) begin
        b_valid <= 1'b1;
      end else if (mv_bc) begin
        b_valid <= 1'b0;
      end
      if (mv_bc) begin
        c_valid <= 1'b1;
      end else if (mv_cd) begin
        c_valid <= 1'b0;
      end
      if (mv_cd) begin
        res_valid <= 1'b1;
      end else if (rdy_d) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_pos   <= pos_cur;
      a_pixel <= pix.grey_pixel;
      a_slot  <= r_cur[SLOT_W-1:0];
      a_col   <= c_cur;
    end
    if (mv_ab) begin
      b_pos <= a_pos;
    end
    if (mv_bc) begin
      c_pos <= b_pos;
    end
    if (mv_cd) begin
      res.edge_value <= value;
      res.out_valid  <= c_pos.ov;
      res.out_row    <= c_pos.row;
      res.out_col    <= c_pos.col;
    end
  end

  lap_edge_linebuf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (acc),
    .rd_addr  (c_cur),
    .wr_en    (mv_ab),
    .wr_addr  (a_col),
    .wr_slot  (a_slot),
    .wr_pixel (a_pixel),
    .column   (column)
  );

  lap_edge_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (mv_ab),
    .up       (column),
    .pixel    (a_pixel),
    .load_en  (mv_bc),
    .resp     (resp)
  );

  always_comb begin
    value = '0;
    if (c_pos.inner && (resp > RESP_W'(edge_threshold))) begin
      if (resp > RESP_W'(SAT_MAX)) begin
        value = PIX_W'(SAT_MAX);
      end else if (resp < 0) begin
        value = '0;
      end else begin
        value = resp[PIX_W-1:0];
      end
    end
  end

  `LE_ASSERT(a_empty_not_stalled, clk, rst, !a_valid |-> !pix_stall)
  `LE_ASSERT(a_value_needs_valid, clk, rst, res_valid && (res.edge_value != '0) |-> res.out_valid)
  `LE_ASSERT(a_frame_start_counts, clk, rst, acc && pix.frame_start |=> (row_cnt == '0) && (col_cnt == CW'(1)))

endmodule
